@@ hdl/slwe_pkg.sv @@
// Package for the status pixel line encoder: widths, codes, reset values, shared types.
// No dependencies; every other file of the block imports it.
package slwe_pkg;

    localparam int unsigned CYC_W      = 10;
    localparam int unsigned BRIGHT_W   = 8;
    localparam int unsigned FRAME_W    = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned PIX_W      = 24;
    localparam int unsigned BITCNT_W   = 5;
    localparam int unsigned FRMCNT_W   = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam int unsigned BLINK_FRAMES_DEF = 4;

    localparam logic [CYC_W-1:0]    ZERO_HIGH_RST = 10'd63;
    localparam logic [CYC_W-1:0]    ZERO_LOW_RST  = 10'd144;
    localparam logic [CYC_W-1:0]    ONE_HIGH_RST  = 10'd126;
    localparam logic [CYC_W-1:0]    ONE_LOW_RST   = 10'd108;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RST    = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_HIGH = 3'd0,
        REG_ZERO_LOW  = 3'd1,
        REG_ONE_HIGH  = 3'd2,
        REG_ONE_LOW   = 3'd3,
        REG_BRIGHT    = 3'd4
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE    = 2'd0,
        ST_RECEIVE = 2'd1,
        ST_CRC_ERR = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    localparam logic KIND_SET   = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic [CYC_W-1:0] zero_high;
        logic [CYC_W-1:0] zero_low;
        logic [CYC_W-1:0] one_high;
        logic [CYC_W-1:0] one_low;
    } t_timing;

    typedef struct packed {
        logic             start;
        logic [PIX_W-1:0] pixel;
    } t_ser_req;

endpackage

@@ hdl/slwe_if.sv @@
// Valid/ready channel interfaces for the status pixel line encoder.
// Depends on slwe_pkg for field widths.
interface slwe_item_if import slwe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [STATUS_W-1:0] new_status;
    logic [FRAME_W-1:0]  frame_number;

    modport source (output valid, kind, new_status, frame_number, input ready);
    modport sink   (input valid, kind, new_status, frame_number, output ready);
endinterface

interface slwe_seg_if import slwe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             pin_level;
    logic [CYC_W-1:0] hold_cycles;
    logic             last_segment;

    modport source (output valid, pin_level, hold_cycles, last_segment, input ready);
    modport sink   (input valid, pin_level, hold_cycles, last_segment, output ready);
endinterface

@@ hdl/slwe_ctrl.sv @@
// Status, blink phase and refresh tracking; bit-serial frame modulo; pixel composition.
// Depends on slwe_pkg and slwe_if.
module slwe_ctrl import slwe_pkg::*; #(
    parameter int unsigned BLINK_FRAMES = BLINK_FRAMES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    slwe_item_if.sink           i_item,
    input  logic [BRIGHT_W-1:0] i_bright,
    input  logic                i_ser_busy,
    output t_ser_req            o_ser_req
);

    localparam int unsigned REM_W = $clog2(BLINK_FRAMES + 1);
    localparam logic [REM_W:0] DIVISOR = (REM_W+1)'(BLINK_FRAMES);
    localparam logic [FRMCNT_W-1:0] LAST_STEP = FRMCNT_W'(FRAME_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_EVAL,
        S_LAUNCH,
        S_SEND
    } t_state;

    t_state               r_state;
    logic [STATUS_W-1:0]  r_status;
    logic                 r_phase_on;
    logic                 r_pending;
    logic [FRAME_W-1:0]   r_frame;
    logic [REM_W-1:0]     r_rem;
    logic [FRMCNT_W-1:0]  r_step;
    logic                 r_ready;
    logic                 r_start;
    logic [PIX_W-1:0]     r_pixel;

    logic [REM_W:0]       n_rem_wide;
    logic [REM_W-1:0]     n_rem;
    logic                 blinks;
    logic                 toggle;
    logic                 n_phase_on;
    logic                 show;
    logic [BRIGHT_W-1:0]  lit;

    assign i_item.ready = r_ready;
    assign o_ser_req    = '{start: r_start, pixel: r_pixel};

    // one remainder step per frame bit, most significant first
    always_comb begin
        n_rem_wide = {r_rem, r_frame[FRAME_W-1]};
        if (n_rem_wide >= DIVISOR) begin
            n_rem_wide = n_rem_wide - DIVISOR;
        end
        n_rem = n_rem_wide[REM_W-1:0];
    end

    assign blinks     = (r_status == ST_RECEIVE) || (r_status == ST_CRC_ERR);
    assign toggle     = blinks && (r_rem == '0);
    assign n_phase_on = toggle ? ~r_phase_on : r_phase_on;
    assign show       = ~blinks || n_phase_on;
    assign lit        = show ? i_bright : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_status   <= ST_IDLE;
            r_phase_on <= 1'b1;
            r_pending  <= 1'b1;
            r_ready    <= 1'b1;
            r_start    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid && r_ready) begin
                        if (i_item.kind == KIND_SET) begin
                            if (i_item.new_status != r_status) begin
                                r_status   <= i_item.new_status;
                                r_phase_on <= 1'b1;
                                r_pending  <= 1'b1;
                            end
                        end else begin
                            r_frame <= i_item.frame_number;
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_ready <= 1'b0;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    r_rem   <= n_rem;
                    r_frame <= {r_frame[FRAME_W-2:0], 1'b0};
                    r_step  <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_phase_on <= n_phase_on;
                    if (r_pending || toggle) begin
                        r_pending <= 1'b0;
                        r_start   <= 1'b1;
                        unique case (r_status)
                            ST_IDLE:    r_pixel <= {8'd0, 8'd0, lit};
                            ST_RECEIVE: r_pixel <= {lit, 8'd0, 8'd0};
                            default:    r_pixel <= {8'd0, lit, 8'd0};
                        endcase
                        r_state <= S_LAUNCH;
                    end else begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_LAUNCH: begin
                    r_start <= 1'b0;
                    r_state <= S_SEND;
                end
                S_SEND: begin
                    if (!i_ser_busy) begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/slwe_ser.sv @@
// Pixel serializer: shifts the 24-bit word out one bit at a time, two segments per bit.
// Depends on slwe_pkg and slwe_if.
module slwe_ser import slwe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ser_req   i_req,
    input  t_timing    i_timing,
    slwe_seg_if.source o_seg,
    output logic       o_busy
);

    localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(PIX_W - 1);

    logic [PIX_W-1:0]    r_pix;
    logic [BITCNT_W-1:0] r_bit;
    logic                r_low;
    logic                r_active;
    logic                r_vld;
    logic                r_pin;
    logic [CYC_W-1:0]    r_hold;
    logic                r_last;

    logic                advance;
    logic [CYC_W-1:0]    n_hold;

    assign advance = r_active && (!r_vld || o_seg.ready);
    assign o_busy  = r_active || r_vld;

    always_comb begin
        case ({r_pix[PIX_W-1], r_low})
            2'b00:   n_hold = i_timing.zero_high;
            2'b01:   n_hold = i_timing.zero_low;
            2'b10:   n_hold = i_timing.one_high;
            default: n_hold = i_timing.one_low;
        endcase
    end

    assign o_seg.valid        = r_vld;
    assign o_seg.pin_level    = r_pin;
    assign o_seg.hold_cycles  = r_hold;
    assign o_seg.last_segment = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_pix    <= i_req.pixel;
                r_bit    <= '0;
                r_low    <= 1'b0;
                r_active <= 1'b1;
            end else if (advance) begin
                r_vld  <= 1'b1;
                r_pin  <= ~r_low;
                r_hold <= n_hold;
                r_last <= r_low && (r_bit == LAST_BIT);
                r_low  <= ~r_low;
                if (r_low) begin
                    r_pix <= {r_pix[PIX_W-2:0], 1'b0};
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == LAST_BIT) begin
                        r_active <= 1'b0;
                    end
                end
            end else if (o_seg.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/status_led_ws2812_encoder.sv @@
// Path: a frame item that refreshes runs the bit-serial frame-count modulo (S_MOD),
// then S_EVAL and S_LAUNCH, before the serializer presents its first segment.
// Throughput: one segment per cycle while the sink is ready, 48 per pixel; the next item
// is taken once the last segment leaves, so a frame item holds the input through the
// serial modulo, refreshing or not, while a set item leaves the input ready.
// Reset (synchronous, active low): status idle, blink lit, refresh pending, timing defaults.
module status_led_ws2812_encoder import slwe_pkg::*; #(
    parameter int unsigned BLINK_FRAMES = BLINK_FRAMES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    slwe_item_if.sink             i_item,
    slwe_seg_if.source            o_seg
);

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    t_timing             r_timing;
    logic [BRIGHT_W-1:0] r_bright;

    // Request from the controller to the serializer, and its busy flag back.
    t_ser_req ser_req;
    logic     ser_busy;

    // Decode the write index; unknown indexes drop the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing <= '{zero_high: ZERO_HIGH_RST, zero_low: ZERO_LOW_RST,
                          one_high: ONE_HIGH_RST, one_low: ONE_LOW_RST};
            r_bright <= BRIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ZERO_HIGH: r_timing.zero_high <= i_cfg_wdata;
                REG_ZERO_LOW:  r_timing.zero_low  <= i_cfg_wdata;
                REG_ONE_HIGH:  r_timing.one_high  <= i_cfg_wdata;
                REG_ONE_LOW:   r_timing.one_low   <= i_cfg_wdata;
                REG_BRIGHT:    r_bright <= i_cfg_wdata[BRIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Controller: takes each transaction, runs the blink modulo serially on frame items,
    // and hands a composed GRB word to the serializer when a refresh is due.
    slwe_ctrl #(
        .BLINK_FRAMES(BLINK_FRAMES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_bright   (r_bright),
        .i_ser_busy (ser_busy),
        .o_ser_req  (ser_req)
    );

    // Serializer: shift the word out MSB first, a high then a low segment per bit,
    // behind an output register that holds under backpressure.
    slwe_ser u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (ser_req),
        .i_timing (r_timing),
        .o_seg    (o_seg),
        .o_busy   (ser_busy)
    );

endmodule

@@ hdl/slwe_chk.sv @@
// Port-level checker for the status pixel line encoder, bound to the top level.
// Depends on slwe_pkg; sees only the top-level ports.
module slwe_chk import slwe_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_pin_level,
    input logic [CYC_W-1:0] i_hold_cycles,
    input logic             i_last_segment
);

    // A stalled segment holds its payload.
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pin_level)
            && $stable(i_hold_cycles) && $stable(i_last_segment))
        else $error("stalled segment changed");

    // No new transaction is taken while a segment is still pending.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !i_out_valid)
        else $error("input ready while segment pending");

    // The closing segment of a pixel is always a low segment.
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_segment |-> !i_pin_level)
        else $error("last segment not low");

    // After a taken high segment the next segment shown is low.
    a_alternate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_pin_level ##1 i_out_valid |-> !i_pin_level)
        else $error("segments do not alternate");

    // Reset leaves no segment pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("segment valid after reset");

endmodule

bind status_led_ws2812_encoder slwe_chk u_slwe_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_seg.valid),
    .i_out_ready    (o_seg.ready),
    .i_pin_level    (o_seg.pin_level),
    .i_hold_cycles  (o_seg.hold_cycles),
    .i_last_segment (o_seg.last_segment)
);

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for status_led_ws2812_encoder: directed and random status and
// frame transactions, GRB segment prediction, random stalls. Needs slwe_pkg, slwe_if.
import slwe_pkg::*;

typedef struct packed {
    logic             pin_level;
    logic [CYC_W-1:0] hold_cycles;
    logic             last_segment;
} t_line_seg;

// Shadow of the encoder state plus the line segments still owed by the block.
class segment_book;
    t_status             status_now;
    bit                  blink_lit;
    bit                  refresh_due;
    logic [CYC_W-1:0]    zero_high;
    logic [CYC_W-1:0]    zero_low;
    logic [CYC_W-1:0]    one_high;
    logic [CYC_W-1:0]    one_low;
    logic [BRIGHT_W-1:0] level;
    t_line_seg           due_segs[$];
    int unsigned         faults;

    function new();
        status_now  = ST_IDLE;
        blink_lit   = 1'b1;
        refresh_due = 1'b1;
        zero_high   = ZERO_HIGH_RST;
        zero_low    = ZERO_LOW_RST;
        one_high    = ONE_HIGH_RST;
        one_low     = ONE_LOW_RST;
        level       = BRIGHT_RST;
        faults      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ZERO_HIGH: zero_high = data[CYC_W-1:0];
            REG_ZERO_LOW:  zero_low  = data[CYC_W-1:0];
            REG_ONE_HIGH:  one_high  = data[CYC_W-1:0];
            REG_ONE_LOW:   one_low   = data[CYC_W-1:0];
            REG_BRIGHT:    level     = data[BRIGHT_W-1:0];
            default: ;
        endcase
    endfunction

    // Returns 0 only for a set transaction that repeats the current status.
    function bit take_item(logic kind, t_status ns, logic [FRAME_W-1:0] frame);
        bit               blinks;
        logic [PIX_W-1:0] grb;
        logic             bit_val;
        t_line_seg        seg;
        if (kind == KIND_SET) begin
            if (ns == status_now)
                return 1'b0;
            status_now  = ns;
            blink_lit   = 1'b1;
            refresh_due = 1'b1;
            return 1'b1;
        end
        blinks = (status_now == ST_RECEIVE) || (status_now == ST_CRC_ERR);
        if (blinks && (frame % BLINK_FRAMES_DEF) == 0) begin
            blink_lit   = !blink_lit;
            refresh_due = 1'b1;
        end
        if (!refresh_due)
            return 1'b1;
        refresh_due = 1'b0;
        grb = '0;
        if (!blinks || blink_lit) begin
            case (status_now)
                ST_IDLE:    grb[0 +: BRIGHT_W]          = level;
                ST_RECEIVE: grb[2*BRIGHT_W +: BRIGHT_W] = level;
                default:    grb[BRIGHT_W +: BRIGHT_W]   = level;
            endcase
        end
        for (int k = 0; k < 2 * PIX_W; k++) begin
            bit_val       = grb[PIX_W - 1 - k / 2];
            seg.pin_level = (k % 2 == 0);
            if (bit_val)
                seg.hold_cycles = seg.pin_level ? one_high : one_low;
            else
                seg.hold_cycles = seg.pin_level ? zero_high : zero_low;
            seg.last_segment = (k == 2 * PIX_W - 1);
            due_segs.push_back(seg);
        end
        return 1'b1;
    endfunction

    function void check_segment(logic pin, logic [CYC_W-1:0] hold, logic last);
        t_line_seg want;
        if (due_segs.size() == 0) begin
            $error("unexpected segment: pin_level %0d hold_cycles %0d last_segment %0d",
                   pin, hold, last);
            faults++;
            return;
        end
        want = due_segs.pop_front();
        if (pin !== want.pin_level) begin
            $error("pin_level: expected %0d, got %0d", want.pin_level, pin);
            faults++;
        end
        if (hold !== want.hold_cycles) begin
            $error("hold_cycles: expected %0d, got %0d", want.hold_cycles, hold);
            faults++;
        end
        if (last !== want.last_segment) begin
            $error("last_segment: expected %0d, got %0d", want.last_segment, last);
            faults++;
        end
    endfunction

    function int unsigned outstanding();
        return due_segs.size();
    endfunction
endclass

module tb;

    localparam int unsigned WAIT_MAX      = 12;
    localparam int unsigned LONG_HOLD     = 400;   // sink hold-off that backs up the block
    localparam int unsigned SETTLE_CYCLES = 100;   // covers a silent frame pass
    localparam int unsigned PHASE_ITEMS   = 50;
    localparam int unsigned NUM_PHASES    = 7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    slwe_item_if item_ch();
    slwe_seg_if  seg_ch();

    segment_book book;
    bit          src_idle_on;
    bit          snk_idle_on;
    bit          long_hold_req;
    int unsigned live_items;

    status_led_ws2812_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_seg       (seg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (every frame refreshing, every
    // segment stalled the full WAIT_MAX, every transaction delayed the full gap).
    initial begin : watchdog
        #20_000_000;
        $display("[status_led_ws2812_encoder] ERROR");
        $finish;
    end

    // Segment sink: draw a stall before each segment, then take it and check it.
    // A pending long hold-off request replaces the stall once.
    initial begin : seg_drain
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = snk_idle_on ? $urandom_range(0, WAIT_MAX) : 0;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                seg_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            seg_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (seg_ch.valid !== 1'b1) @(posedge i_clk);
            book.check_segment(seg_ch.pin_level, seg_ch.hold_cycles, seg_ch.last_segment);
            @(negedge i_clk);
        end
    end

    // Enter and leave at a falling edge. Valid stays high on return so that a
    // back-to-back transaction needs only one assignment per time step; callers
    // that let time pass without a transaction drop it through settle.
    task automatic send_item(input logic kind, input t_status ns,
                             input logic [FRAME_W-1:0] frame);
        int unsigned gap;
        gap = src_idle_on ? $urandom_range(0, WAIT_MAX) : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.kind         <= kind;
        item_ch.new_status   <= ns;
        item_ch.frame_number <= frame;
        item_ch.valid        <= 1'b1;
        @(posedge i_clk);
        while (item_ch.ready !== 1'b1) @(posedge i_clk);
        void'(book.take_item(kind, ns, frame));
        live_items++;
        @(negedge i_clk);
    endtask

    // Drop valid, drain every owed segment, then let a silent frame pass finish.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (book.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input int unsigned idx, input int unsigned data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_wdata <= data[CFG_DATA_W-1:0];
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        book.write_reg(idx[CFG_IDX_W-1:0], data[CFG_DATA_W-1:0]);
        @(negedge i_clk);
    endtask

    // Brightness gets the full 10-bit word so its unused upper bits toggle too.
    task automatic load_timing(input int unsigned zh, input int unsigned zl,
                               input int unsigned oh, input int unsigned ol,
                               input int unsigned br);
        write_reg(REG_ZERO_HIGH, zh);
        write_reg(REG_ZERO_LOW,  zl);
        write_reg(REG_ONE_HIGH,  oh);
        write_reg(REG_ONE_LOW,   ol);
        write_reg(REG_BRIGHT,    br);
    endtask

    // Mostly well-formed runs: a status change followed by consecutive frame
    // counts (step 1 or a whole blink interval) so blinking toggles often; the
    // rest is noise with random kind, status and frame count.
    task automatic run_random(input int unsigned quota);
        int unsigned        goal;
        int unsigned        run_len;
        int unsigned        step;
        t_status            pick;
        logic [FRAME_W-1:0] frame;
        goal = live_items + quota;
        while (live_items < goal) begin
            src_idle_on = ($urandom_range(0, 2) != 0);
            snk_idle_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 4) == 0) begin
                run_len = $urandom_range(1, 4);
                repeat (run_len)
                    send_item($urandom_range(0, 1) == 1, t_status'($urandom_range(0, 3)),
                              $urandom);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: pick = ST_RECEIVE;
                    4, 5, 6:    pick = ST_CRC_ERR;
                    7:          pick = ST_IDLE;
                    default:    pick = ST_TIMEOUT;
                endcase
                send_item(KIND_SET, pick, $urandom);
                frame   = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 64);
                step    = ($urandom_range(0, 2) == 0) ? BLINK_FRAMES_DEF : 1;
                run_len = $urandom_range(3, 12);
                repeat (run_len) begin
                    // Occasionally repeat the status: must change nothing.
                    if ($urandom_range(0, 7) == 0)
                        send_item(KIND_SET, pick, $urandom);
                    send_item(KIND_FRAME, t_status'($urandom_range(0, 3)), frame);
                    frame += step;
                end
            end
        end
    endtask

    initial begin : stimulus
        book                 = new();
        i_rst_n              = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = REG_ZERO_HIGH;
        cfg_wdata            = '0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_SET;
        item_ch.new_status   = ST_IDLE;
        item_ch.frame_number = '0;
        seg_ch.ready         = 1'b0;
        src_idle_on          = 1'b0;
        snk_idle_on          = 1'b0;
        long_hold_req        = 1'b0;
        live_items           = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pass at reset timing; first half without any idling.
        send_item(KIND_FRAME, ST_IDLE,    32'd0);          // refresh left by reset: blue
        send_item(KIND_FRAME, ST_IDLE,    32'hFFFF_FFFF);  // nothing pending
        send_item(KIND_SET,   ST_IDLE,    32'hFFFF_FFFF);  // same status, frame ignored
        send_item(KIND_SET,   ST_RECEIVE, 32'd0);
        send_item(KIND_FRAME, ST_TIMEOUT, 32'd1);          // status ignored on frames: green
        send_item(KIND_FRAME, ST_IDLE,    32'd4);          // blink off: black
        send_item(KIND_FRAME, ST_IDLE,    32'd5);
        send_item(KIND_FRAME, ST_IDLE,    32'd8);          // blink back on
        send_item(KIND_SET,   ST_CRC_ERR, 32'hA5A5_A5A5);
        send_item(KIND_FRAME, ST_CRC_ERR, 32'hFFFF_FFFC);  // toggles off the forced-on phase
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        send_item(KIND_FRAME, ST_RECEIVE, 32'd0);          // back on: red
        send_item(KIND_SET,   ST_TIMEOUT, 32'h5A5A_5A5A);
        send_item(KIND_FRAME, ST_IDLE,    32'd12);         // timeout never blinks
        send_item(KIND_FRAME, ST_IDLE,    32'd16);
        send_item(KIND_SET,   ST_TIMEOUT, 32'd0);          // same status again
        send_item(KIND_SET,   ST_IDLE,    32'd7);
        send_item(KIND_FRAME, ST_CRC_ERR, 32'd3);
        send_item(KIND_SET,   ST_RECEIVE, 32'd0);
        send_item(KIND_SET,   ST_IDLE,    32'd0);          // refresh stays pending
        send_item(KIND_FRAME, ST_RECEIVE, 32'd4);          // idle ignores the interval
        send_item(KIND_SET,   ST_CRC_ERR, 32'd0);
        send_item(KIND_SET,   ST_CRC_ERR, 32'd0);
        send_item(KIND_FRAME, ST_TIMEOUT, 32'd2);
        settle();

        for (int p = 1; p <= NUM_PHASES; p++) begin
            case (p)
                1: load_timing(1023, 1023, 1023, 1023, 10'h3FF);
                2: load_timing(1, 1, 1, 1, 10'h300);     // brightness lands on 0
                3: begin
                    load_timing(0, 10'h2AA, 10'h155, 0, 10'h0FF);
                    // Unmapped indexes: the block must ignore these writes.
                    for (int k = REG_BRIGHT + 1; k < (1 << CFG_IDX_W); k++)
                        write_reg(k, $urandom_range(0, 1023));
                end
                4: load_timing(10'h155, 0, 0, 10'h2AA, $urandom_range(0, 1023));
                default: load_timing($urandom_range(1, 1023), $urandom_range(1, 1023),
                                     $urandom_range(1, 1023), $urandom_range(1, 1023),
                                     $urandom_range(0, 1023));
            endcase
            if (p == 4) begin
                // Back up the block: hold the sink off while refreshing frames
                // keep arriving with no gap.
                src_idle_on   = 1'b0;
                long_hold_req = 1'b1;
                send_item(KIND_SET, ST_IDLE,    $urandom);
                send_item(KIND_SET, ST_RECEIVE, $urandom);
                for (int k = 0; k < 6; k++)
                    send_item(KIND_FRAME, ST_IDLE, k * BLINK_FRAMES_DEF);
            end
            run_random(PHASE_ITEMS);
            settle();
        end

        if (book.faults == 0 && book.outstanding() == 0)
            $display("[status_led_ws2812_encoder] OK");
        else
            $display("[status_led_ws2812_encoder] ERROR");
        $finish;
    end

endmodule
